>>> rtl/core/ccod_pkg.sv
// Package for the cell-averaging CFAR onset detector.
// Holds widths, register indexes, reset values and the controller/datapath structs.
// No dependencies.
package ccod_pkg;

  // default ring length
  localparam int WINDOW_DEF = 20;

  // field widths
  localparam int ENERGY_W = 32;
  localparam int FACTOR_W = 16;
  localparam int GUARD_W  = 5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_CELLS      = 1'd1;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd2560;  // 10.0 in Q8.8
  localparam logic [GUARD_W-1:0]  GUARD_RST  = 5'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // take the input word, write it into the ring
    logic rd;        // read one reference entry
    logic mul;       // form both sides of the compare
    logic out_load;  // capture the decision into the output register
  } ccod_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;      // ring filled before the current word
    logic no_ref;    // guard covers the whole ring
    logic last_rd;   // this read is the final reference entry
  } ccod_stat_t;

endpackage

>>> rtl/core/ccod_in_if.sv
// Input channel of the onset detector: one energy word per handshake.
// Depends on ccod_pkg.
interface ccod_in_if
  import ccod_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

>>> rtl/core/ccod_out_if.sv
// Result channel of the onset detector: detection flag and window-full flag.
// No dependencies.
interface ccod_out_if;
  logic valid;
  logic ready;
  logic detected;
  logic window_full;

  modport source (output valid, output detected, output window_full, input ready);
  modport sink   (input valid, input detected, input window_full, output ready);
endinterface

>>> rtl/core/ccod_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccod_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ccod_datapath.sv
// Datapath of the onset detector: config registers, history ring, read pointer,
// accumulator, the two products and the output word. Depends on ccod_pkg, ccod_ram.
module ccod_datapath
  import ccod_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ENERGY_W-1:0]   energy,
  input  ccod_cmd_t             cmd,
  output ccod_stat_t            stat,
  output logic                  detected,
  output logic                  window_full
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CW     = (CNT_W > GUARD_W) ? CNT_W : GUARD_W;
  localparam int SUM_W  = ENERGY_W + CNT_W;
  localparam int LHS_W  = ENERGY_W + CNT_W;
  localparam int RHS_W  = SUM_W + FACTOR_W;

  localparam logic [CW:0]       WIN_C     = (CW + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  FILL_MAX  = CNT_W'(WINDOW);

  logic [FACTOR_W-1:0] factor_r;
  logic [GUARD_W-1:0]  guard_r;
  logic [SLOT_W-1:0]   write_slot_r, write_slot_nxt;
  logic [CNT_W-1:0]    fill_count_r, fill_count_nxt;
  logic [SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    count_r;
  logic                rd_vld_r;
  logic [ENERGY_W-1:0] energy_r;
  logic                full_r;
  logic                noref_r;
  logic [SUM_W-1:0]    acc_r;
  logic [LHS_W-1:0]    lhs_r;
  logic [RHS_W-1:0]    rhs_r;
  logic                det_r;
  logic                wf_r;

  logic [CW:0]          newest_ext;
  logic [CW:0]          guard_ext;
  logic [CW:0]          start_slot;
  logic [CW:0]          ref_count;
  logic [ENERGY_W-1:0]  rd_data;
  logic                 det_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RST;
      guard_r  <= GUARD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_THRESHOLD_FACTOR: factor_r <= cfg_data[FACTOR_W-1:0];
        REG_GUARD_CELLS:      guard_r  <= cfg_data[GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  // status from the pre-update ring state
  assign newest_ext = (CW + 1)'(write_slot_r);
  assign guard_ext  = (CW + 1)'(guard_r);
  assign ref_count  = WIN_C - guard_ext;
  assign start_slot = (newest_ext >= guard_ext) ? (newest_ext - guard_ext)
                                                : (newest_ext + WIN_C - guard_ext);

  assign stat.full    = (fill_count_r == FILL_MAX);
  assign stat.no_ref  = (guard_ext >= WIN_C);
  assign stat.last_rd = (rem_r == CNT_W'(1));

  // ring pointers
  always_comb begin
    write_slot_nxt = (write_slot_r == SLOT_LAST) ? '0 : write_slot_r + 1'b1;
    fill_count_nxt = stat.full ? fill_count_r : fill_count_r + 1'b1;
    rd_slot_nxt    = (rd_slot_r == '0) ? SLOT_LAST : rd_slot_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      fill_count_r <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.load) begin
        write_slot_r <= write_slot_nxt;
        fill_count_r <= fill_count_nxt;
      end
    end
  end

  // history ring
  ccod_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (write_slot_r),
    .wdata (energy),
    .re    (cmd.rd),
    .raddr (rd_slot_r),
    .rdata (rd_data)
  );

  // word capture, reference walk and accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      energy_r  <= energy;
      full_r    <= stat.full;
      noref_r   <= stat.no_ref;
      rd_slot_r <= start_slot[SLOT_W-1:0];
      rem_r     <= ref_count[CNT_W-1:0];
      count_r   <= ref_count[CNT_W-1:0];
      acc_r     <= '0;
    end else begin
      if (cmd.rd) begin
        rd_slot_r <= rd_slot_nxt;
        rem_r     <= rem_r - 1'b1;
      end
      if (rd_vld_r) begin
        acc_r <= acc_r + SUM_W'(rd_data);
      end
    end
  end

  // both sides of energy*count*256 > sum*factor
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      lhs_r <= LHS_W'(energy_r) * LHS_W'(count_r);
      rhs_r <= RHS_W'(acc_r) * RHS_W'(factor_r);
    end
  end

  always_comb begin
    if (!full_r) begin
      det_nxt = 1'b0;
    end else if (noref_r) begin
      det_nxt = (energy_r != '0);
    end else begin
      det_nxt = (RHS_W'({lhs_r, 8'h00}) > rhs_r);
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      det_r <= det_nxt;
      wf_r  <= full_r;
    end
  end

  assign detected    = det_r;
  assign window_full = wf_r;

endmodule

>>> rtl/core/ccod_ctrl.sv
// Controller of the onset detector: sequences load, reference reads, products
// and the output handshake. Depends on ccod_pkg.
module ccod_ctrl
  import ccod_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ccod_stat_t stat,
  output ccod_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) && rst_n;
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = (!stat.full || stat.no_ref) ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (stat.last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/ca_cfar_onset_detector_top.sv
// Top level of the cell-averaging CFAR onset detector.
// Depends on ccod_pkg, ccod_in_if, ccod_out_if, ccod_ctrl, ccod_datapath.
//
// Use:
//   in_ch carries one energy word (unsigned, 32 bit) per handshake; out_ch returns
//   one word per input: detected and window_full. Configuration is written through
//   cfg_we/cfg_idx/cfg_data (index 0: threshold factor, Q8.8; index 1: guard cells)
//   while the block is idle.
// Sequence:
//   While the ring is still filling, and when the guard covers the whole ring, no
//   reference entries are read: the accepted word goes straight to the output state.
//   Otherwise the WINDOW - guard_cells reference entries are read one a cycle
//   through the single read port of the history RAM, followed by a drain state for
//   the last read, a product state and the output state, which loads the output
//   register once it is free. in_ch.ready returns high in the cycle after the
//   output register is loaded; no new word is taken before the last one has
//   reached the output register.
// Reset and stall:
//   Synchronous reset empties the ring (fill count zero), resets both registers
//   and drops out_ch.valid; no clearing pass is needed. A result held by a stalled
//   receiver stays in the output register; the next word may still be accepted and
//   processed, and waits for the output register before it is delivered.
module ca_cfar_onset_detector_top
  import ccod_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ccod_in_if.sink               in_ch,
  ccod_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ccod_cmd_t  cmd;
  ccod_stat_t stat;

  // sequencing
  ccod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // ring, accumulation and compare
  ccod_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .energy      (in_ch.energy),
    .cmd         (cmd),
    .stat        (stat),
    .detected    (out_ch.detected),
    .window_full (out_ch.window_full)
  );

endmodule

>>> rtl/core/ccod_checker.sv
// Port-level checker for the onset detector, bound to the top level.
// No package dependency.
module ccod_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_detected,
  input logic out_window_full
);

  logic seen_full_r;

  // remembers that a full-window result has been delivered since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_full_r <= 1'b0;
    end else if (out_valid && out_ready && out_window_full) begin
      seen_full_r <= 1'b1;
    end
  end

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_detected) && $stable(out_window_full))
    else $error("result word changed while stalled");

  // no detection can be flagged before the ring is full
  a_fill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_full |-> !out_detected)
    else $error("detection reported while ring filling");

  // once full, the ring stays full until reset
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_full_r |-> out_window_full)
    else $error("window_full fell after the ring was full");

  // the block is not ready again in the cycle after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

endmodule

bind ca_cfar_onset_detector_top ccod_checker u_ccod_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_detected    (out_ch.detected),
  .out_window_full (out_ch.window_full)
);

>>> tb/ccod_result_checker.sv
// Result checker for the CFAR onset detector: watches both channels and the config port.
// Predicts detected/window_full per energy word and compares in order.
// Depends on ccod_pkg, ccod_in_if, ccod_out_if.
module ccod_result_checker
  import ccod_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ccod_in_if                    in_mon,
  ccod_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct {
    logic [ENERGY_W-1:0] energy;
    logic                detected;
    logic                window_full;
  } onset_verdict_t;

  // shadow of the block state and registers
  logic [ENERGY_W-1:0] energy_hist [WINDOW];
  int unsigned         next_slot;
  int unsigned         filled;
  logic [FACTOR_W-1:0] factor;
  logic [GUARD_W-1:0]  guard;

  onset_verdict_t verdict_q[$];
  int             errors = 0;

  // store the word in the history, then test it against the reference cells
  function automatic onset_verdict_t judge_energy(input logic [ENERGY_W-1:0] e);
    onset_verdict_t v;
    int unsigned    newest;
    int unsigned    slot;
    int unsigned    age;
    logic [63:0]    ref_sum;
    logic [63:0]    cells;
    newest = next_slot;
    energy_hist[newest] = e;
    next_slot = (newest + 1) % WINDOW;
    v.energy = e;
    v.detected = 1'b0;
    v.window_full = 1'b0;
    if (filled < WINDOW) begin
      filled++;
      return v;
    end
    ref_sum = '0;
    cells = '0;
    // age 0 is the word just stored; the guard skips the newest entries
    for (age = guard; age < WINDOW; age++) begin
      slot = (newest + WINDOW - age) % WINDOW;
      ref_sum += 64'(energy_hist[slot]);
      cells++;
    end
    v.window_full = 1'b1;
    if (cells == 0)
      v.detected = (e != '0);
    else
      v.detected = (64'(e) * cells * 64'd256) > (ref_sum * 64'(factor));
    return v;
  endfunction

  always @(posedge clk) begin
    onset_verdict_t want;
    if (!rst_n) begin
      factor = FACTOR_RST;
      guard = GUARD_RST;
      next_slot = 0;
      filled = 0;
      verdict_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_THRESHOLD_FACTOR: factor = cfg_data[FACTOR_W-1:0];
          REG_GUARD_CELLS:      guard = cfg_data[GUARD_W-1:0];
          default: ;
        endcase
      end
      // result word leaving the block
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: expected none, actual detected=%0b window_full=%0b",
                   $time, out_mon.detected, out_mon.window_full);
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.detected !== want.detected) begin
            errors++;
            $display("%0t: detected mismatch (energy %h): expected %0b, actual %0b",
                     $time, want.energy, want.detected, out_mon.detected);
          end
          if (out_mon.window_full !== want.window_full) begin
            errors++;
            $display("%0t: window_full mismatch (energy %h): expected %0b, actual %0b",
                     $time, want.energy, want.window_full, out_mon.window_full);
          end
        end
      end
      // energy word entering the block
      if (in_mon.valid && in_mon.ready)
        verdict_q.push_back(judge_energy(in_mon.energy));
    end
    fail_count <= errors;
    outstanding <= verdict_q.size();
  end

endmodule

>>> tb/tb_ca_cfar_onset_detector_top.sv
// Testbench top for the CFAR onset detector: clock, reset, stimulus and verdict.
// Energy words go through phases of register settings; checking is in ccod_result_checker.
// Depends on ccod_pkg, ccod_in_if, ccod_out_if, ca_cfar_onset_detector_top, ccod_result_checker.
module tb_ca_cfar_onset_detector_top
  import ccod_pkg::*;
;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 1000;
  localparam int PHASES       = 9;
  localparam int DRAIN_CYCLES = WINDOW_DEF + 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm;
  int                    fail_count;
  int                    outstanding;
  int                    cycles = 0;
  int                    stall_left = 0;

  ccod_in_if  in_ch ();
  ccod_out_if out_ch ();

  ca_cfar_onset_detector_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  ccod_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: short stalls now and then, rarely a long one, none when calm
  always @(posedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < 2) begin
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 1);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one energy word, with an occasional gap before it
  task automatic send_word(input logic [ENERGY_W-1:0] e);
    int gap;
    if (!calm && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 40);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.energy <= e;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait until every result word is back and the block has gone quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [FACTOR_W-1:0] f, input logic [GUARD_W-1:0] g);
    cfg_we <= 1'b1;
    cfg_idx <= REG_THRESHOLD_FACTOR;
    cfg_data <= CFG_DATA_W'(f);
    @(posedge clk);
    cfg_idx <= REG_GUARD_CELLS;
    cfg_data <= CFG_DATA_W'(g);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly background noise around a level, with bursts, full-range words and extremes
  function automatic logic [ENERGY_W-1:0] pick_energy(input int unsigned lvl);
    int unsigned         roll;
    logic [ENERGY_W-1:0] e;
    roll = $urandom_range(99);
    e = $urandom_range(lvl, lvl * 2);
    if (roll < 70)
      return e;
    else if (roll < 85)
      return e << $urandom_range(1, 20);
    else if (roll < 95)
      return $urandom();
    else if (roll < 97)
      return '0;
    else
      return '1;
  endfunction

  initial begin
    logic [ENERGY_W-1:0] fill_words [20];
    logic [FACTOR_W-1:0] f;
    logic [GUARD_W-1:0]  g;
    int unsigned         lvl;
    in_ch.valid = 1'b0;
    in_ch.energy = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_THRESHOLD_FACTOR;
    cfg_data = '0;
    calm = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the ring at reset settings: extremes and bit patterns first
    fill_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h0000_0001, 32'h8000_0000, 32'd1000, 32'd1100, 32'd1200, 32'd900,
                   32'd1050, 32'd980, 32'd1010, 32'd1300, 32'd870, 32'd1150,
                   32'd990, 32'd1020, 32'd1080, 32'd940};
    foreach (fill_words[i]) send_word(fill_words[i]);
    // first words after the ring is full
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0000_0001);
    send_word(32'h7FFF_FFFF);

    // phases: factor zero, widest factor unguarded, one reference cell, full-ring guard, and more
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin f = '0;       g = 5'd2;  end
        1: begin f = '1;       g = 5'd0;  end
        2: begin f = 16'd1;    g = 5'd19; end
        3: begin f = 16'd256;  g = 5'd20; end
        4: begin f = 16'd2560; g = 5'd1;  end
        5: begin f = 16'd512;  g = 5'd31; end
        default: begin
          f = FACTOR_W'($urandom_range(64, 8192));
          g = GUARD_W'($urandom_range(0, 19));
        end
      endcase
      set_config(f, g);
      calm <= (p == 4);
      send_word('0);
      send_word('1);
      lvl = $urandom_range(1, 4000);
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) send_word(pick_energy(lvl));
    end

    wait_idle();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
